>>> sv/pti_pkg.sv
// ----------------------------------------------------------------------------
// pti_pkg: shared definitions for the plane triple intersection core
// Default widths, the threshold reset value and the sideband record that
// travels with an item through the division pipeline.
// ----------------------------------------------------------------------------
package pti_pkg;

	localparam int unsigned COORD_WIDTH_DEF = 32;
	localparam int unsigned FRAC_BITS_DEF   = 16;
	localparam int unsigned THRESH_RESET    = 1;

	// Per-item flags carried alongside the divider lanes.
	typedef struct packed {
		logic       found;
		logic [2:0] neg;
		logic [2:0] ovf;
	} pti_side_t;

endpackage

>>> sv/pti_if.sv
// ----------------------------------------------------------------------------
// pti interfaces: valid/ready channels of the plane triple intersection core
// Plane triple input, intersection point output and threshold write channel.
// ----------------------------------------------------------------------------
interface pti_plane_if #(
	parameter int unsigned NW = 18,
	parameter int unsigned CW = 32
);
	logic                 valid;
	logic                 ready;
	logic signed [NW-1:0] first_normal_x;
	logic signed [NW-1:0] first_normal_y;
	logic signed [NW-1:0] first_normal_z;
	logic signed [CW-1:0] first_distance;
	logic signed [NW-1:0] second_normal_x;
	logic signed [NW-1:0] second_normal_y;
	logic signed [NW-1:0] second_normal_z;
	logic signed [CW-1:0] second_distance;
	logic signed [NW-1:0] third_normal_x;
	logic signed [NW-1:0] third_normal_y;
	logic signed [NW-1:0] third_normal_z;
	logic signed [CW-1:0] third_distance;

	modport source (
		output valid, first_normal_x, first_normal_y, first_normal_z, first_distance,
		output second_normal_x, second_normal_y, second_normal_z, second_distance,
		output third_normal_x, third_normal_y, third_normal_z, third_distance,
		input  ready
	);
	modport sink (
		input  valid, first_normal_x, first_normal_y, first_normal_z, first_distance,
		input  second_normal_x, second_normal_y, second_normal_z, second_distance,
		input  third_normal_x, third_normal_y, third_normal_z, third_distance,
		output ready
	);
endinterface

interface pti_point_if #(
	parameter int unsigned CW = 32
);
	logic                 valid;
	logic                 ready;
	logic signed [CW-1:0] point_x;
	logic signed [CW-1:0] point_y;
	logic signed [CW-1:0] point_z;
	logic                 found;
	logic                 clipped;

	modport source (output valid, point_x, point_y, point_z, found, clipped, input ready);
	modport sink   (input valid, point_x, point_y, point_z, found, clipped, output ready);
endinterface

interface pti_cfg_if #(
	parameter int unsigned TW = 17
);
	logic          valid;
	logic          ready;
	logic [TW-1:0] det_threshold;

	modport source (output valid, det_threshold, input ready);
	modport sink   (input valid, det_threshold, output ready);
endinterface

>>> sv/pti_div_stage.sv
// ----------------------------------------------------------------------------
// pti_div_stage: one restoring division step for three lanes
// Each stage brings in one dividend bit per lane and retires one quotient bit.
// ----------------------------------------------------------------------------
module pti_div_stage #(
	parameter int unsigned DW = 57,
	parameter int unsigned CW = 32
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    en,
	input  logic                    in_valid,
	input  pti_pkg::pti_side_t      in_side,
	input  logic [DW-1:0]           in_d,
	input  logic [2:0][DW-1:0]      in_r,
	input  logic [2:0][CW-1:0]      in_n,
	input  logic [2:0][CW-1:0]      in_q,
	output logic                    out_valid,
	output pti_pkg::pti_side_t      out_side,
	output logic [DW-1:0]           out_d,
	output logic [2:0][DW-1:0]      out_r,
	output logic [2:0][CW-1:0]      out_n,
	output logic [2:0][CW-1:0]      out_q
);
	import pti_pkg::*;

	logic [2:0][DW-1:0] r_next;
	logic [2:0]         q_bit;

	always_comb begin
		logic [DW:0] t;
		for (int k = 0; k < 3; k++) begin
			t = {in_r[k], in_n[k][CW-1]};
			q_bit[k] = (t >= {1'b0, in_d});
			r_next[k] = q_bit[k] ? DW'(t - {1'b0, in_d}) : t[DW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en) begin
			out_valid <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_side <= in_side;
			out_d    <= in_d;
			for (int k = 0; k < 3; k++) begin
				out_r[k] <= r_next[k];
				out_n[k] <= {in_n[k][CW-2:0], 1'b0};
				out_q[k] <= {in_q[k][CW-2:0], q_bit[k]};
			end
		end
	end

endmodule

>>> sv/plane_triple_intersect_core.sv
// Throughput: one item per cycle while the skid register is empty; six
// arithmetic stages feed a chain of COORD_WIDTH restoring division stages,
// each retiring one quotient bit. Reset clears every stage valid bit and the
// output and skid valid bits, and sets the determinant threshold to 1.
// ----------------------------------------------------------------------------
// plane_triple_intersect_core: intersection point of three planes
// Solves n1.x = d1, n2.x = d2, n3.x = d3 in signed fixed point with Cramer's
// rule and a pipelined long division, saturating the result.
// ----------------------------------------------------------------------------
module plane_triple_intersect_core #(
	parameter int unsigned COORD_WIDTH = pti_pkg::COORD_WIDTH_DEF,
	parameter int unsigned FRAC_BITS   = pti_pkg::FRAC_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	pti_plane_if.sink   plane,
	pti_point_if.source point,
	pti_cfg_if.sink     cfg
);
	import pti_pkg::*;

	// Normal width, product, cross product, determinant and numerator widths.
	localparam int unsigned CW   = COORD_WIDTH;
	localparam int unsigned NW   = FRAC_BITS + 2;
	localparam int unsigned TW   = FRAC_BITS + 1;
	localparam int unsigned PW   = 2 * NW;
	localparam int unsigned XW   = PW + 1;
	localparam int unsigned DETW = NW + XW + 2;
	localparam int unsigned MPW  = CW + NW + 1;
	localparam int unsigned NUMW = CW + XW + 2;
	localparam int unsigned NSW  = NUMW + FRAC_BITS;
	localparam int unsigned CMPW = DETW + CW;
	localparam int unsigned RESW = 3 * CW + 2;

	// The whole pipeline advances together; it only holds while the skid
	// register is occupied, so a waiting result never blocks new items
	// until two results are queued at the output.
	logic en;
	logic sk_valid_q;
	assign en          = !sk_valid_q;
	assign plane.ready = en;

	// Threshold register; the user must write it only while the block is idle, the block does not enforce this.
	logic [TW-1:0] thr_q;
	assign cfg.ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= TW'(THRESH_RESET);
		end else if (cfg.valid) begin
			thr_q <= cfg.det_threshold;
		end
	end

	// Plane fields as arrays: nn[plane][axis], dd[plane].
	logic signed [NW-1:0] nn [3][3];
	logic signed [CW-1:0] dd [3];
	assign nn[0][0] = plane.first_normal_x;
	assign nn[0][1] = plane.first_normal_y;
	assign nn[0][2] = plane.first_normal_z;
	assign nn[1][0] = plane.second_normal_x;
	assign nn[1][1] = plane.second_normal_y;
	assign nn[1][2] = plane.second_normal_z;
	assign nn[2][0] = plane.third_normal_x;
	assign nn[2][1] = plane.third_normal_y;
	assign nn[2][2] = plane.third_normal_z;
	assign dd[0]    = plane.first_distance;
	assign dd[1]    = plane.second_distance;
	assign dd[2]    = plane.third_distance;

	// Stage 1: the eighteen products of the three cross products.
	// Cross index 0 is n2 x n3, index 1 is n3 x n1 and index 2 is n1 x n2.
	logic signed [PW-1:0] pa_c [3][3];
	logic signed [PW-1:0] pb_c [3][3];
	always_comb begin
		int u, v, k1, k2;
		for (int i = 0; i < 3; i++) begin
			u = (i == 2) ? 0 : i + 1;
			v = (i == 0) ? 2 : i - 1;
			for (int k = 0; k < 3; k++) begin
				k1 = (k == 2) ? 0 : k + 1;
				k2 = (k == 0) ? 2 : k - 1;
				pa_c[i][k] = nn[u][k1] * nn[v][k2];
				pb_c[i][k] = nn[u][k2] * nn[v][k1];
			end
		end
	end

	logic                 valid_s1;
	logic signed [PW-1:0] pa_s1 [3][3];
	logic signed [PW-1:0] pb_s1 [3][3];
	logic signed [NW-1:0] n1_s1 [3];
	logic signed [CW-1:0] d_s1  [3];

	// Stage 2: cross products.
	logic                 valid_s2;
	logic signed [XW-1:0] cr_s2 [3][3];
	logic signed [NW-1:0] n1_s2 [3];
	logic signed [CW-1:0] d_s2  [3];

	// Stage 3: determinant terms and split numerator products. Each cross
	// component is cut into an unsigned low part and a signed high part so
	// that no multiplier grows much past the coordinate width.
	logic                        valid_s3;
	logic signed [NW+XW-1:0]     detp_s3 [3];
	logic signed [MPW-1:0]       plo_s3  [3][3];
	logic signed [MPW-1:0]       phi_s3  [3][3];

	// Stage 4: determinant and the three numerators.
	logic                   valid_s4;
	logic signed [DETW-1:0] det_s4;
	logic signed [NUMW-1:0] num_s4 [3];

	// Stage 5: magnitudes, signs and the singularity test.
	logic                   valid_s5;
	logic [DETW-1:0]        dmag_s5;
	logic [NUMW-1:0]        nmag_s5 [3];
	pti_side_t              side_s5;

	// Stage 6: overflow pre-check and the first partial remainder.
	logic                   valid_s6;
	logic [DETW-1:0]        dmag_s6;
	logic [2:0][DETW-1:0]   rem_s6;
	logic [2:0][CW-1:0]     nlo_s6;
	pti_side_t              side_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
		end else if (en) begin
			valid_s1 <= plane.valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
			valid_s6 <= valid_s5;
		end
	end

	// Stage 4 sums.
	logic signed [DETW-1:0] det_c;
	logic signed [NUMW-1:0] num_c [3];
	always_comb begin
		det_c = DETW'(detp_s3[0]) + DETW'(detp_s3[1]) + DETW'(detp_s3[2]);
		for (int k = 0; k < 3; k++) begin
			num_c[k] = '0;
			for (int i = 0; i < 3; i++) begin
				num_c[k] = num_c[k] + (NUMW'(phi_s3[i][k]) <<< NW) + NUMW'(plo_s3[i][k]);
			end
		end
	end

	// Stage 5 magnitudes and the threshold compare. The threshold carries
	// FRAC_BITS fraction bits, the determinant three times as many.
	logic            dneg_c;
	logic [DETW-1:0] dmag_c;
	logic [NUMW-1:0] nmag_c [3];
	logic [2:0]      nneg_c;
	always_comb begin
		dneg_c = det_s4[DETW-1];
		dmag_c = dneg_c ? DETW'(-det_s4) : DETW'(det_s4);
		for (int k = 0; k < 3; k++) begin
			nneg_c[k] = num_s4[k][NUMW-1];
			nmag_c[k] = nneg_c[k] ? NUMW'(-num_s4[k]) : NUMW'(num_s4[k]);
		end
	end

	// Stage 6: the scaled numerator is compared with the divisor shifted by
	// the coordinate width; anything at or above that certainly saturates,
	// and below it the quotient fits in CW bits.
	logic [NSW-1:0]  nsh_c [3];
	logic [2:0]      ovf_c;
	always_comb begin
		for (int k = 0; k < 3; k++) begin
			nsh_c[k] = {nmag_s5[k], {FRAC_BITS{1'b0}}};
			ovf_c[k] = (CMPW'(nsh_c[k]) >= (CMPW'(dmag_s5) << CW));
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				for (int k = 0; k < 3; k++) begin
					pa_s1[i][k] <= pa_c[i][k];
					pb_s1[i][k] <= pb_c[i][k];
					cr_s2[i][k] <= XW'(pa_s1[i][k]) - XW'(pb_s1[i][k]);
					plo_s3[i][k] <= d_s2[i] * $signed({1'b0, cr_s2[i][k][NW-1:0]});
					phi_s3[i][k] <= d_s2[i] * $signed(cr_s2[i][k][XW-1:NW]);
				end
				n1_s1[i]   <= nn[0][i];
				d_s1[i]    <= dd[i];
				n1_s2[i]   <= n1_s1[i];
				d_s2[i]    <= d_s1[i];
				detp_s3[i] <= n1_s2[i] * cr_s2[0][i];
				num_s4[i]  <= num_c[i];
				nmag_s5[i] <= nmag_c[i];
				rem_s6[i]  <= DETW'(nsh_c[i] >> CW);
				nlo_s6[i]  <= nsh_c[i][CW-1:0];
			end
			det_s4        <= det_c;
			dmag_s5       <= dmag_c;
			side_s5.found <= (dmag_c != '0) && !(dmag_c < (DETW'(thr_q) << (2 * FRAC_BITS)));
			side_s5.neg   <= nneg_c ^ {3{dneg_c}};
			side_s5.ovf   <= '0;
			dmag_s6       <= dmag_s5;
			side_s6.found <= side_s5.found;
			side_s6.neg   <= side_s5.neg;
			side_s6.ovf   <= ovf_c;
		end
	end

	// Division chain: one quotient bit per stage, most significant first.
	logic                 dv_valid [CW+1];
	pti_side_t            dv_side  [CW+1];
	logic [DETW-1:0]      dv_d     [CW+1];
	logic [2:0][DETW-1:0] dv_r     [CW+1];
	logic [2:0][CW-1:0]   dv_n     [CW+1];
	logic [2:0][CW-1:0]   dv_q     [CW+1];

	assign dv_valid[0] = valid_s6;
	assign dv_side[0]  = side_s6;
	assign dv_d[0]     = dmag_s6;
	assign dv_r[0]     = rem_s6;
	assign dv_n[0]     = nlo_s6;
	assign dv_q[0]     = '0;

	for (genvar j = 0; j < CW; j++) begin : g_div
		pti_div_stage #(
			.DW (DETW),
			.CW (CW)
		) u_stage (
			.clk       (clk),
			.arst_n    (arst_n),
			.en        (en),
			.in_valid  (dv_valid[j]),
			.in_side   (dv_side[j]),
			.in_d      (dv_d[j]),
			.in_r      (dv_r[j]),
			.in_n      (dv_n[j]),
			.in_q      (dv_q[j]),
			.out_valid (dv_valid[j+1]),
			.out_side  (dv_side[j+1]),
			.out_d     (dv_d[j+1]),
			.out_r     (dv_r[j+1]),
			.out_n     (dv_n[j+1]),
			.out_q     (dv_q[j+1])
		);
	end

	// Saturation and sign restore. A negative result may reach the most
	// negative code, a positive one stops one short of it in magnitude.
	localparam logic [CW-1:0] LIM_POS = {1'b0, {(CW-1){1'b1}}};
	localparam logic [CW-1:0] LIM_NEG = {1'b1, {(CW-1){1'b0}}};

	pti_side_t      fin_side;
	logic [CW-1:0]  coord_c [3];
	logic [2:0]     sat_c;
	logic [RESW-1:0] res_c;
	always_comb begin
		logic [CW-1:0] lim, mag;
		fin_side = dv_side[CW];
		for (int k = 0; k < 3; k++) begin
			lim        = fin_side.neg[k] ? LIM_NEG : LIM_POS;
			sat_c[k]   = fin_side.ovf[k] || (dv_q[CW][k] > lim);
			mag        = sat_c[k] ? lim : dv_q[CW][k];
			coord_c[k] = !fin_side.found ? '0 : (fin_side.neg[k] ? CW'(-mag) : mag);
		end
		res_c = {coord_c[0], coord_c[1], coord_c[2], fin_side.found,
			fin_side.found && (sat_c != '0)};
	end

	// Output register plus one skid entry.
	logic            fire;
	logic            o_valid_q;
	logic [RESW-1:0] o_res_q;
	logic [RESW-1:0] sk_res_q;
	assign fire = en && dv_valid[CW];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			o_valid_q  <= 1'b0;
			sk_valid_q <= 1'b0;
		end else if (point.ready || !o_valid_q) begin
			if (sk_valid_q) begin
				o_valid_q  <= 1'b1;
				sk_valid_q <= 1'b0;
			end else begin
				o_valid_q <= fire;
			end
		end else if (fire) begin
			sk_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (point.ready || !o_valid_q) begin
			o_res_q <= sk_valid_q ? sk_res_q : res_c;
		end else if (fire) begin
			sk_res_q <= res_c;
		end
	end

	assign point.valid   = o_valid_q;
	assign point.point_x = o_res_q[RESW-1 -: CW];
	assign point.point_y = o_res_q[RESW-1-CW -: CW];
	assign point.point_z = o_res_q[RESW-1-2*CW -: CW];
	assign point.found   = o_res_q[1];
	assign point.clipped = o_res_q[0];

	// A queued skid entry always sits behind a held output item.
	assert property (@(posedge clk) disable iff (!arst_n) sk_valid_q |-> o_valid_q)
		else $error("skid entry held without an output item");

	// A singular item leaves all coordinates at zero and no clip flag.
	assert property (@(posedge clk) disable iff (!arst_n)
		(o_valid_q && !point.found) |->
		(point.point_x == '0 && point.point_y == '0 && point.point_z == '0 && !point.clipped))
		else $error("singular item carries a nonzero result");

	// Saturation is only reported for items that found a point.
	assert property (@(posedge clk) disable iff (!arst_n)
		(o_valid_q && point.clipped) |-> point.found)
		else $error("clip flag set without a found point");

	// The skid entry, the only cause of a stall, stays held while the output stalls.
	assert property (@(posedge clk) disable iff (!arst_n)
		(sk_valid_q && !point.ready) |=> sk_valid_q)
		else $error("skid entry lost while the output stalled");

endmodule
